### rtl/playfair_digraph_cipher_defines.svh
// Assertion macros shared by the cipher RTL.
`ifndef PLAYFAIR_DIGRAPH_CIPHER_DEFINES_SVH
`define PLAYFAIR_DIGRAPH_CIPHER_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define PDC_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define PDC_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

### rtl/pdc_pkg.sv
package pdc_pkg;

  // Request codes of the input channel.
  typedef enum logic [2:0] {
    REQ_CLEAR = 3'd0,
    REQ_KEY   = 3'd1,
    REQ_END   = 3'd2,
    REQ_ENC   = 3'd3,
    REQ_DEC   = 3'd4
  } req_t;

  // Status codes of the result channel.
  typedef enum logic [1:0] {
    STAT_OK         = 2'd0,
    STAT_NONLETTER  = 2'd1,
    STAT_INCOMPLETE = 2'd2
  } status_t;

  // A decoded ASCII letter.
  typedef struct packed {
    logic       ok;
    logic [4:0] idx;
  } letter_t;

  localparam logic [4:0] SQ_CELLS    = 5'd25;
  localparam logic [4:0] ALPHA_LAST  = 5'd25;
  localparam logic [4:0] LETTER_I    = 5'd8;
  localparam logic [4:0] LETTER_J    = 5'd9;
  localparam logic [2:0] DIM_LAST    = 3'd4;
  localparam logic [7:0] ASCII_UP_A  = 8'h41;
  localparam logic [7:0] ASCII_UP_Z  = 8'h5A;
  localparam logic [7:0] ASCII_LO_A  = 8'h61;
  localparam logic [7:0] ASCII_LO_Z  = 8'h7A;

  // Letter index 0..25 for an ASCII letter of either case.
  function automatic letter_t letter_index(input logic [7:0] ch);
    letter_t r;
    r.ok  = 1'b0;
    r.idx = '0;
    if (ch >= ASCII_UP_A && ch <= ASCII_UP_Z) begin
      r.ok  = 1'b1;
      r.idx = 5'(ch - ASCII_UP_A);
    end else if (ch >= ASCII_LO_A && ch <= ASCII_LO_Z) begin
      r.ok  = 1'b1;
      r.idx = 5'(ch - ASCII_LO_A);
    end
    return r;
  endfunction

  // Row of a cell index 0..24; (pos * 13) >> 6 equals pos / 5 on that range.
  function automatic logic [2:0] pos_row(input logic [4:0] pos);
    logic [8:0] prod;
    prod = 9'(pos) * 9'd13;
    return prod[8:6];
  endfunction

  // Column of a cell index 0..24.
  function automatic logic [2:0] pos_col(input logic [4:0] pos);
    logic [4:0] base;
    base = {2'b00, pos_row(pos)} * 5'd5;
    return 3'(pos - base);
  endfunction

  // Cell index from row and column.
  function automatic logic [4:0] sq_addr(input logic [2:0] row, input logic [2:0] col);
    return 5'({2'b00, row} * 5'd5) + {2'b00, col};
  endfunction

  // Step one place forward or back around a row or column.
  function automatic logic [2:0] wrap_step(input logic [2:0] x, input logic back);
    logic [2:0] r;
    if (back) begin
      r = (x == 3'd0) ? DIM_LAST : 3'(x - 3'd1);
    end else begin
      r = (x == DIM_LAST) ? 3'd0 : 3'(x + 3'd1);
    end
    return r;
  endfunction

endpackage

### rtl/playfair_digraph_cipher.sv
// Channel   Ports                                              Handshake
// --------  -------------------------------------------------  -----------------------------
// input     in_req_type, in_first_letter, in_second_letter     start high while busy is low
// result    out_first_out, out_second_out, out_status          out_strobe, one cycle
//
// Key letters, clears, rejected pairs, unknown codes and ends on a ready square
// give their result in the cycle after the transaction, with busy low.
// An accepted pair's result passes the position memory read and then the key
// square memory read; busy is high while the key square read is made.
// Any other end item walks the 26 letters at one per cycle.
// Reset (rst_n low at a clock edge) empties the square; the receiver never stalls.
module playfair_digraph_cipher (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       start,
  output logic       busy,
  input  logic [2:0] in_req_type,
  input  logic [7:0] in_first_letter,
  input  logic [7:0] in_second_letter,
  output logic       out_strobe,
  output logic [7:0] out_first_out,
  output logic [7:0] out_second_out,
  output logic [1:0] out_status
);
  import pdc_pkg::*;

`include "playfair_digraph_cipher_defines.svh"

  typedef enum logic [1:0] {
    S_IDLE,
    S_POS,
    S_FILL
  } state_t;

  state_t      state_r;
  logic [25:0] used_r;
  logic [4:0]  fill_r;
  logic        ready_r;
  logic [4:0]  fill_idx_r;
  logic        dec_r;
  logic        out_valid_r;
  logic        out_sq_r;
  status_t     out_status_r;

  // Key square and position map storage.
  logic [4:0]  sq_mem  [25];
  logic [4:0]  pos_mem [26];
  logic [4:0]  pos_rd_a_r;
  logic [4:0]  pos_rd_b_r;
  logic [4:0]  sq_rd_a_r;
  logic [4:0]  sq_rd_b_r;

  logic        acc;
  req_t        req;
  letter_t     la;
  letter_t     lb;
  logic [4:0]  msg_a;
  logic [4:0]  msg_b;
  logic        key_we;
  logic        fill_we;
  logic        mem_we;
  logic [4:0]  wr_letter;
  logic [2:0]  ra;
  logic [2:0]  ca;
  logic [2:0]  rb;
  logic [2:0]  cb;
  logic [4:0]  sq_addr_a;
  logic [4:0]  sq_addr_b;

  assign busy = (state_r == S_POS) || (state_r == S_FILL);
  assign acc  = start && !busy;
  assign req  = req_t'(in_req_type);
  assign la   = letter_index(in_first_letter);
  assign lb   = letter_index(in_second_letter);

  // Message letters with j folded onto i.
  assign msg_a = (la.idx == LETTER_J) ? LETTER_I : la.idx;
  assign msg_b = (lb.idx == LETTER_J) ? LETTER_I : lb.idx;

  // A key letter places itself, or the end walk places the next unused letter.
  assign key_we = acc && (req == REQ_KEY) && la.ok && !ready_r && (la.idx != LETTER_J)
                  && !used_r[la.idx] && (fill_r < SQ_CELLS);
  assign fill_we = (state_r == S_FILL) && (fill_idx_r != LETTER_J)
                   && !used_r[fill_idx_r] && (fill_r < SQ_CELLS);
  assign mem_we    = key_we || fill_we;
  assign wr_letter = (state_r == S_FILL) ? fill_idx_r : la.idx;

  // Square addresses from the positions read at the pair's transaction.
  always_comb begin
    ra = pos_row(pos_rd_a_r);
    ca = pos_col(pos_rd_a_r);
    rb = pos_row(pos_rd_b_r);
    cb = pos_col(pos_rd_b_r);
    if (ra == rb) begin
      sq_addr_a = sq_addr(ra, wrap_step(ca, dec_r));
      sq_addr_b = sq_addr(rb, wrap_step(cb, dec_r));
    end else if (ca == cb) begin
      sq_addr_a = sq_addr(wrap_step(ra, dec_r), ca);
      sq_addr_b = sq_addr(wrap_step(rb, dec_r), cb);
    end else begin
      sq_addr_a = sq_addr(ra, cb);
      sq_addr_b = sq_addr(rb, ca);
    end
  end

  // Position memory: one write port, two registered read ports. Writes happen
  // only while the square is incomplete and reads matter only once it is
  // ready, so no forwarding is needed.
  always_ff @(posedge clk) begin
    if (mem_we) begin
      pos_mem[wr_letter] <= fill_r;
    end
    pos_rd_a_r <= pos_mem[msg_a];
    pos_rd_b_r <= pos_mem[msg_b];
  end

  // Key square memory: same arrangement.
  always_ff @(posedge clk) begin
    if (mem_we) begin
      sq_mem[fill_r] <= wr_letter;
    end
    sq_rd_a_r <= sq_mem[sq_addr_a];
    sq_rd_b_r <= sq_mem[sq_addr_b];
  end

  // Control state and registered result.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      used_r       <= '0;
      fill_r       <= '0;
      ready_r      <= 1'b0;
      fill_idx_r   <= '0;
      dec_r        <= 1'b0;
      out_valid_r  <= 1'b0;
      out_sq_r     <= 1'b0;
      out_status_r <= STAT_OK;
    end else begin
      out_valid_r  <= 1'b0;
      out_sq_r     <= 1'b0;
      out_status_r <= STAT_OK;
      if (mem_we) begin
        used_r[wr_letter] <= 1'b1;
        fill_r            <= 5'(fill_r + 5'd1);
      end
      unique case (state_r)
        S_IDLE: begin
          if (acc) begin
            case (req)
              REQ_CLEAR: begin
                used_r      <= '0;
                fill_r      <= '0;
                ready_r     <= 1'b0;
                out_valid_r <= 1'b1;
              end
              REQ_KEY: begin
                out_valid_r  <= 1'b1;
                out_status_r <= la.ok ? STAT_OK : STAT_NONLETTER;
              end
              REQ_END: begin
                if (ready_r) begin
                  out_valid_r <= 1'b1;
                end else begin
                  fill_idx_r <= '0;
                  state_r    <= S_FILL;
                end
              end
              REQ_ENC, REQ_DEC: begin
                if (!ready_r) begin
                  out_valid_r  <= 1'b1;
                  out_status_r <= STAT_INCOMPLETE;
                end else if (!la.ok || !lb.ok) begin
                  out_valid_r  <= 1'b1;
                  out_status_r <= STAT_NONLETTER;
                end else begin
                  dec_r   <= (req == REQ_DEC);
                  state_r <= S_POS;
                end
              end
              default: begin
                out_valid_r <= 1'b1;
              end
            endcase
          end
        end
        S_POS: begin
          out_valid_r <= 1'b1;
          out_sq_r    <= 1'b1;
          state_r     <= S_IDLE;
        end
        S_FILL: begin
          if (fill_idx_r == ALPHA_LAST) begin
            ready_r     <= 1'b1;
            out_valid_r <= 1'b1;
            state_r     <= S_IDLE;
          end else begin
            fill_idx_r <= 5'(fill_idx_r + 5'd1);
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  // Result ports; letters come straight from the square read registers.
  assign out_strobe     = out_valid_r;
  assign out_first_out  = out_sq_r ? 8'(ASCII_LO_A + {3'b000, sq_rd_a_r}) : 8'd0;
  assign out_second_out = out_sq_r ? 8'(ASCII_LO_A + {3'b000, sq_rd_b_r}) : 8'd0;
  assign out_status     = out_status_r;

  // The square is never written once it is complete.
  `PDC_ASSERT_NOW(a_no_write_ready, clk, rst_n, mem_we, !ready_r, "square written while ready")
  // The fill count never passes the square size.
  `PDC_ASSERT_NOW(a_fill_bound, clk, rst_n, 1'b1, fill_r <= SQ_CELLS, "fill count overflow")
  // A pair in flight delivers its letters in the next cycle.
  `PDC_ASSERT_NEXT(a_pair_result, clk, rst_n, state_r == S_POS, out_valid_r && out_sq_r,
    "pair result missing")
  // Every transaction yields a result at once or starts a multicycle operation.
  `PDC_ASSERT_NEXT(a_acc_progress, clk, rst_n, acc,
    out_valid_r || state_r == S_POS || state_r == S_FILL, "transaction dropped")
  // Letters are shown only together with the strobe and an ok status.
  `PDC_ASSERT_NOW(a_sq_strobe, clk, rst_n, out_sq_r, out_valid_r && out_status_r == STAT_OK,
    "letters without strobe")

endmodule
